/* rtl/core/cantxq_pkg.sv */
package cantxq_pkg;

  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = 4;

  localparam int ID_W   = 11;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;

  localparam int CFG_IDX_W = 1;

  localparam logic [ID_W-1:0]   INJECT_ID_RST   = 11'h6C1;
  localparam logic [DATA_W-1:0] INJECT_DATA_RST = 64'h0101_032B_00C0_2E10;
  localparam logic [LEN_W-1:0]  INJECT_LEN      = 4'd8;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_TICK   = 2'd1,
    OP_DONE   = 2'd2,
    OP_ARM    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INJECT_ID   = 1'b0,
    CFG_INJECT_DATA = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } frame_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;     // take the request on the input ports and update state
    logic release_; // result has been delivered
  } cmd_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [PTR_W:0] ptr_count(input logic [PTR_W-1:0] w,
                                               input logic [PTR_W-1:0] r);
    logic [PTR_W:0] c;
    if (w >= r) begin
      c = {1'b0, w} - {1'b0, r};
    end else begin
      c = {1'b0, w} + (PTR_W+1)'(DEPTH) - {1'b0, r};
    end
    return c;
  endfunction

endpackage

/* rtl/core/cantxq_ctrl.sv */
module cantxq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output cantxq_pkg::cmd_t   cmd
);
  import cantxq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_RESULT = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = (state_r == S_RESULT);
  assign cmd.step     = in_ready && in_valid;
  assign cmd.release_ = out_valid && out_ready;

endmodule

/* rtl/core/cantxq_dp.sv */
module cantxq_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cantxq_pkg::cmd_t                      cmd,
  input  logic [1:0]                            in_op,
  input  logic [cantxq_pkg::ID_W-1:0]           in_frame_id,
  input  logic [cantxq_pkg::LEN_W-1:0]          in_frame_len,
  input  logic [cantxq_pkg::DATA_W-1:0]         in_frame_data,
  input  logic                                  cfg_we,
  input  logic [cantxq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cantxq_pkg::DATA_W-1:0]         cfg_data,
  output logic                                  out_send_valid,
  output logic [cantxq_pkg::ID_W-1:0]           out_send_id,
  output logic [cantxq_pkg::LEN_W-1:0]          out_send_len,
  output logic [cantxq_pkg::DATA_W-1:0]         out_send_data,
  output logic                                  out_dropped,
  output logic [cantxq_pkg::CNT_W-1:0]          out_queue_count
);
  import cantxq_pkg::*;

  // Configuration
  logic [ID_W-1:0]   inject_id_r;
  logic [DATA_W-1:0] inject_data_r;

  // Queue control state
  logic             cts_r;
  logic             cts_nxt;
  logic             pending_r;
  logic             pending_nxt;
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] wp_nxt;
  logic [PTR_W-1:0] rp_r;
  logic [PTR_W-1:0] rp_nxt;

  frame_t slot_mem_r [DEPTH];
  frame_t head_r;

  // Result registers
  logic             res_send_r;
  logic             res_from_mem_r;
  logic             res_drop_r;
  logic [CNT_W-1:0] res_count_r;
  frame_t           byp_r;

  op_t              op;
  logic             sub_en;
  frame_t           sub_frame;
  logic             empty;
  logic             full;
  logic             bypass;
  logic             drop;
  logic             append;
  logic             cts_mid;
  logic             empty_mid;
  logic             send_head;
  logic [PTR_W:0]   cur_count;
  logic [PTR_W:0]   nxt_count;
  frame_t           send_frame;

  assign op = op_t'(in_op);

  always_comb begin
    sub_en = (op == OP_SUBMIT) || ((op == OP_TICK) && pending_r);
    if (op == OP_SUBMIT) begin
      sub_frame.id   = in_frame_id;
      sub_frame.len  = in_frame_len;
      sub_frame.data = in_frame_data;
    end else begin
      sub_frame.id   = inject_id_r;
      sub_frame.len  = INJECT_LEN;
      sub_frame.data = inject_data_r;
    end

    cur_count = ptr_count(wp_r, rp_r);
    empty     = (wp_r == rp_r);
    full      = (cur_count == (PTR_W+1)'(DEPTH - 1));

    bypass = sub_en && empty && cts_r;
    drop   = sub_en && !bypass && full;
    append = sub_en && !bypass && !full;

    cts_mid   = cts_r && !bypass;
    wp_nxt    = append ? ptr_inc(wp_r) : wp_r;
    empty_mid = (wp_nxt == rp_r);

    // A plain submit that is dropped never pulls from the ring; a tick does.
    if (op == OP_SUBMIT) begin
      send_head = append && cts_r;
    end else if (op == OP_TICK) begin
      send_head = cts_mid && !empty_mid;
    end else begin
      send_head = 1'b0;
    end

    rp_nxt = send_head ? ptr_inc(rp_r) : rp_r;

    if (op == OP_DONE) begin
      cts_nxt = 1'b1;
    end else if (bypass || send_head) begin
      cts_nxt = 1'b0;
    end else begin
      cts_nxt = cts_r;
    end

    if (op == OP_ARM) begin
      pending_nxt = 1'b1;
    end else if (op == OP_TICK) begin
      pending_nxt = 1'b0;
    end else begin
      pending_nxt = pending_r;
    end

    nxt_count = ptr_count(wp_nxt, rp_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inject_id_r   <= INJECT_ID_RST;
      inject_data_r <= INJECT_DATA_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INJECT_ID:   inject_id_r   <= cfg_data[ID_W-1:0];
        CFG_INJECT_DATA: inject_data_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cts_r          <= 1'b1;
      pending_r      <= 1'b0;
      wp_r           <= '0;
      rp_r           <= '0;
      res_send_r     <= 1'b0;
      res_from_mem_r <= 1'b0;
      res_drop_r     <= 1'b0;
      res_count_r    <= '0;
    end else if (cmd.step) begin
      cts_r          <= cts_nxt;
      pending_r      <= pending_nxt;
      wp_r           <= wp_nxt;
      rp_r           <= rp_nxt;
      res_send_r     <= bypass || send_head;
      res_from_mem_r <= send_head;
      res_drop_r     <= drop;
      res_count_r    <= nxt_count[CNT_W-1:0];
    end else if (cmd.release_) begin
      res_send_r <= 1'b0;
      res_drop_r <= 1'b0;
    end
  end

  // The head slot is never the slot written in the same step, since a send
  // from the ring only happens when the ring already held a frame.
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      if (append) begin
        slot_mem_r[wp_r] <= sub_frame;
      end
      head_r <= slot_mem_r[rp_r];
      byp_r  <= sub_frame;
    end
  end

  assign send_frame = res_from_mem_r ? head_r : byp_r;

  assign out_send_valid  = res_send_r;
  assign out_send_id     = res_send_r ? send_frame.id   : '0;
  assign out_send_len    = res_send_r ? send_frame.len  : '0;
  assign out_send_data   = res_send_r ? send_frame.data : '0;
  assign out_dropped     = res_drop_r;
  assign out_queue_count = res_count_r;

endmodule

/* rtl/core/can_tx_frame_queue.sv */
// A request is accepted and its result is offered in the following cycle, held until
// taken. The controller takes a new request only after the single result register
// has been emptied.
// Reset (synchronous, rst_n low): clear-to-send set, injection disarmed, ring
// empty, injection registers at defaults; slot storage is not cleared.
module can_tx_frame_queue (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_op,
  input  logic [cantxq_pkg::ID_W-1:0]           in_frame_id,
  input  logic [cantxq_pkg::LEN_W-1:0]          in_frame_len,
  input  logic [cantxq_pkg::DATA_W-1:0]         in_frame_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_send_valid,
  output logic [cantxq_pkg::ID_W-1:0]           out_send_id,
  output logic [cantxq_pkg::LEN_W-1:0]          out_send_len,
  output logic [cantxq_pkg::DATA_W-1:0]         out_send_data,
  output logic                                  out_dropped,
  output logic [cantxq_pkg::CNT_W-1:0]          out_queue_count,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cantxq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cantxq_pkg::DATA_W-1:0]         cfg_data
);
  import cantxq_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  cantxq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  cantxq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_op           (in_op),
    .in_frame_id     (in_frame_id),
    .in_frame_len    (in_frame_len),
    .in_frame_data   (in_frame_data),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_send_valid  (out_send_valid),
    .out_send_id     (out_send_id),
    .out_send_len    (out_send_len),
    .out_send_data   (out_send_data),
    .out_dropped     (out_dropped),
    .out_queue_count (out_queue_count)
  );

endmodule

/* dv/can_tx_frame_queue_tb.sv */
`timescale 1ns / 100ps

module can_tx_frame_queue_tb;
  import cantxq_pkg::*;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } tx_request_t;

  typedef struct packed {
    logic              sent;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    logic              dropped;
    logic [CNT_W-1:0]  count;
  } tx_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_op = OP_SUBMIT;
  logic [ID_W-1:0]   in_frame_id = '0;
  logic [LEN_W-1:0]  in_frame_len = '0;
  logic [DATA_W-1:0] in_frame_data = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_send_valid;
  logic [ID_W-1:0]   out_send_id;
  logic [LEN_W-1:0]  out_send_len;
  logic [DATA_W-1:0] out_send_data;
  logic              out_dropped;
  logic [CNT_W-1:0]  out_queue_count;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_INJECT_ID;
  logic [DATA_W-1:0]    cfg_data = '0;

  can_tx_frame_queue dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_frame_id     (in_frame_id),
    .in_frame_len    (in_frame_len),
    .in_frame_data   (in_frame_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_send_valid  (out_send_valid),
    .out_send_id     (out_send_id),
    .out_send_len    (out_send_len),
    .out_send_data   (out_send_data),
    .out_dropped     (out_dropped),
    .out_queue_count (out_queue_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the queue, the controller handshake and the injection registers.
  logic              q_clear;
  logic              q_armed;
  logic [PTR_W-1:0]  q_wr;
  logic [PTR_W-1:0]  q_rd;
  frame_t            q_slots [DEPTH];
  logic [ID_W-1:0]   q_inj_id;
  logic [DATA_W-1:0] q_inj_data;

  tx_request_t frame_requests[$];
  tx_result_t  sends_expected[$];

  tx_request_t tx_cur;
  int tx_gap = 0;
  int rx_gap = 0;
  int tx_idle_max = 2;
  int rx_idle_max = 2;

  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_handovers = 0;
  int n_drops = 0;
  int n_injects = 0;
  int n_cfg_writes = 0;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return PTR_W'((int'(p) + 1) % DEPTH);
  endfunction

  function automatic void hand_over(inout tx_result_t res, input frame_t f);
    q_clear  = 1'b0;
    res.sent = 1'b1;
    res.id   = f.id;
    res.len  = f.len;
    res.data = f.data;
    n_handovers++;
  endfunction

  function automatic void send_oldest(inout tx_result_t res);
    if (q_wr != q_rd) begin
      hand_over(res, q_slots[q_rd]);
      q_rd = ring_next(q_rd);
    end
  endfunction

  function automatic void enqueue_frame(inout tx_result_t res, input frame_t f);
    logic [PTR_W-1:0] nxt;
    if (q_wr == q_rd && q_clear) begin
      hand_over(res, f);
    end else begin
      nxt = ring_next(q_wr);
      if (nxt == q_rd) begin
        res.dropped = 1'b1;
        n_drops++;
      end else begin
        q_slots[q_wr] = f;
        q_wr = nxt;
        if (q_clear) begin
          send_oldest(res);
        end
      end
    end
  endfunction

  function automatic tx_result_t predict_send(input tx_request_t req);
    tx_result_t res;
    frame_t     f;
    res = '0;
    case (req.op)
      OP_SUBMIT: begin
        f = '{id: req.id, len: req.len, data: req.data};
        enqueue_frame(res, f);
      end
      OP_TICK: begin
        if (q_armed) begin
          f = '{id: q_inj_id, len: INJECT_LEN, data: q_inj_data};
          enqueue_frame(res, f);
          q_armed = 1'b0;
          n_injects++;
        end
        if (q_clear) begin
          send_oldest(res);
        end
      end
      OP_DONE: q_clear = 1'b1;
      default: q_armed = 1'b1;
    endcase
    res.count = CNT_W'((int'(q_wr) + DEPTH - int'(q_rd)) % DEPTH);
    return res;
  endfunction

  function automatic string fmt_result(input tx_result_t r);
    return $sformatf("sent=%0b id=%h len=%0d data=%h dropped=%0b count=%0d",
                     r.sent, r.id, r.len, r.data, r.dropped, r.count);
  endfunction

  task automatic report_mismatch(input string what, input tx_result_t want,
                                 input tx_result_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected %s", fmt_result(want));
      $display("  actual   %s", fmt_result(got));
    end
  endtask

  // Request driver: one request in flight, payload held until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        sends_expected.push_back(predict_send(tx_cur));
        n_requests++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          in_valid <= 1'b0;
          tx_gap--;
        end else if (frame_requests.size() != 0) begin
          tx_cur = frame_requests.pop_front();
          in_op         <= tx_cur.op;
          in_frame_id   <= tx_cur.id;
          in_frame_len  <= tx_cur.len;
          in_frame_data <= tx_cur.data;
          in_valid      <= 1'b1;
          tx_gap = $urandom_range(0, tx_idle_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    tx_result_t got;
    tx_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_send_valid, out_send_id, out_send_len, out_send_data,
               out_dropped, out_queue_count};
        n_results++;
        if (sends_expected.size() == 0) begin
          report_mismatch("result with no request outstanding", '0, got);
        end else begin
          want = sends_expected.pop_front();
          if (got !== want) begin
            report_mismatch("result mismatch", want, got);
          end
        end
        rx_gap = $urandom_range(0, rx_idle_max);
      end
      if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic tx_request_t frame_req(input op_t op, input logic [ID_W-1:0] id,
                                            input logic [LEN_W-1:0] len,
                                            input logic [DATA_W-1:0] data);
    tx_request_t r;
    r.op   = op;
    r.id   = id;
    r.len  = len;
    r.data = data;
    return r;
  endfunction

  // Weights are percentages for submit, tick and completion; the rest arms injection.
  function automatic tx_request_t random_req(input int w_submit, input int w_tick,
                                             input int w_done);
    tx_request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < w_submit) begin
      r.op = OP_SUBMIT;
    end else if (pick < w_submit + w_tick) begin
      r.op = OP_TICK;
    end else if (pick < w_submit + w_tick + w_done) begin
      r.op = OP_DONE;
    end else begin
      r.op = OP_ARM;
    end
    case ($urandom_range(0, 7))
      0: r.id = '0;
      1: r.id = '1;
      default: r.id = ID_W'($urandom);
    endcase
    if ($urandom_range(0, 5) == 0) begin
      r.len = LEN_W'($urandom_range(9, 15));
    end else begin
      r.len = LEN_W'($urandom_range(0, 8));
    end
    r.data = {$urandom, $urandom};
    return r;
  endfunction

  task automatic load_random(input int n, input int w_submit, input int w_tick,
                             input int w_done);
    @(negedge clk);
    repeat (n) frame_requests.push_back(random_req(w_submit, w_tick, w_done));
  endtask

  // Waits until every request is taken and every result has come back.
  task automatic drain();
    @(negedge clk);
    while (frame_requests.size() != 0 || in_valid || sends_expected.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_INJECT_ID) begin
      q_inj_id = val[ID_W-1:0];
    end else begin
      q_inj_data = val;
    end
    n_cfg_writes++;
  endtask

  initial begin
    q_clear    = 1'b1;
    q_armed    = 1'b0;
    q_wr       = '0;
    q_rd       = '0;
    q_inj_id   = INJECT_ID_RST;
    q_inj_data = INJECT_DATA_RST;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: bypass, queuing, odd lengths, repeated completion and arming,
    // an injection and a send in one tick, and an injection into an empty ring.
    @(negedge clk);
    frame_requests.push_back(frame_req(OP_SUBMIT, '0, 4'd0, '0));
    frame_requests.push_back(frame_req(OP_SUBMIT, '1, 4'd8, '1));
    frame_requests.push_back(frame_req(OP_SUBMIT, 11'h2AA, 4'd15, 64'h5555_5555_5555_5555));
    frame_requests.push_back(frame_req(OP_SUBMIT, 11'h555, 4'd9, 64'hAAAA_AAAA_AAAA_AAAA));
    frame_requests.push_back(frame_req(OP_DONE, '0, '0, '0));
    frame_requests.push_back(frame_req(OP_DONE, '0, '0, '0));
    frame_requests.push_back(frame_req(OP_TICK, '0, '0, '0));
    frame_requests.push_back(frame_req(OP_ARM, '0, '0, '0));
    frame_requests.push_back(frame_req(OP_ARM, '0, '0, '0));
    frame_requests.push_back(frame_req(OP_DONE, '0, '0, '0));
    frame_requests.push_back(frame_req(OP_TICK, '0, '0, '0));
    frame_requests.push_back(frame_req(OP_TICK, '0, '0, '0));
    repeat (3) begin
      frame_requests.push_back(frame_req(OP_DONE, '0, '0, '0));
      frame_requests.push_back(frame_req(OP_TICK, '0, '0, '0));
    end
    frame_requests.push_back(frame_req(OP_DONE, '0, '0, '0));
    frame_requests.push_back(frame_req(OP_ARM, '0, '0, '0));
    frame_requests.push_back(frame_req(OP_TICK, '0, '0, '0));
    frame_requests.push_back(frame_req(OP_TICK, '0, '0, '0));
    frame_requests.push_back(frame_req(OP_SUBMIT, 11'h7FE, 4'd1, 64'h8000_0000_0000_0001));
    drain();

    write_reg(CFG_INJECT_ID, '0);
    write_reg(CFG_INJECT_DATA, '0);
    tx_idle_max = 4;
    rx_idle_max = 4;
    load_random(140, 40, 25, 25);
    drain();

    // Submissions dominate here so the ring fills up and starts dropping.
    write_reg(CFG_INJECT_ID, DATA_W'(11'h7FF));
    write_reg(CFG_INJECT_DATA, '1);
    tx_idle_max = 1;
    rx_idle_max = 4;
    load_random(140, 70, 10, 8);
    drain();

    write_reg(CFG_INJECT_DATA, {$urandom, $urandom});
    write_reg(CFG_INJECT_ID, DATA_W'($urandom_range(0, 2047)));
    tx_idle_max = 4;
    rx_idle_max = 0;
    load_random(140, 20, 35, 38);
    drain();

    write_reg(CFG_INJECT_ID, DATA_W'(11'h2AA));
    write_reg(CFG_INJECT_DATA, {$urandom, $urandom});
    tx_idle_max = 0;
    rx_idle_max = 0;
    load_random(130, 45, 25, 22);
    drain();
    repeat (8) @(posedge clk);

    $display("Ran %0d requests (%0d injections) under %0d register writes.",
             n_requests, n_injects, n_cfg_writes);
    $display("Checked %0d results: %0d frames handed over, %0d frames dropped.",
             n_results, n_handovers, n_drops);
    if (errors == 0) begin
      $display("can_tx_frame_queue test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("can_tx_frame_queue test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", sends_expected.size());
    $display("can_tx_frame_queue test failed");
    $finish;
  end

endmodule
